[sv/mlsam_pkg.sv]
`timescale 1ns / 1ps

package mlsam_pkg;

    // Lines that have sample fields in one item.
    localparam int FIELD_LINES = 4;

    localparam int LINES_DEF     = 4;
    localparam int LEVEL_MAX_DEF = 32767;

    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 16;
    localparam int MASTER_W = 15;

    // One sample times one level, the sum over the lanes, then times the master level.
    localparam int PROD_W = SAMPLE_W + LEVEL_W + 1;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int MIX_W  = SUM_W + MASTER_W + 1;

    // Pipeline stages of the divide and clip unit.
    localparam int SCALE_STAGES = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int IN_DATA_W  = 2 * FIELD_LINES * SAMPLE_W;
    localparam int OUT_DATA_W = 2 * SAMPLE_W;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [LEVEL_W-1:0]  t_level;
    typedef logic        [MASTER_W-1:0] t_master;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [PAIR_W-1:0]   t_pair;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [MIX_W-1:0]    t_mix;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE0_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE1_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE2_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE3_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_MUTE = 3'd5;

endpackage

[sv/mlsam_lane.sv]
`timescale 1ns / 1ps

module mlsam_lane (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_active,
    input  mlsam_pkg::t_sample i_left,
    input  mlsam_pkg::t_sample i_right,
    input  mlsam_pkg::t_level  i_level,
    output mlsam_pkg::t_prod   o_left,
    output mlsam_pkg::t_prod   o_right
);
    import mlsam_pkg::*;

    t_prod r_left;
    t_prod r_right;
    t_prod n_left;
    t_prod n_right;

    always_comb begin
        n_left  = PROD_W'(i_left)  * PROD_W'(signed'({1'b0, i_level}));
        n_right = PROD_W'(i_right) * PROD_W'(signed'({1'b0, i_level}));
    end

    // An inactive line adds nothing to the mix.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_left  <= i_active ? n_left  : '0;
            r_right <= i_active ? n_right : '0;
        end
    end

    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

[sv/mlsam_merge.sv]
`timescale 1ns / 1ps

module mlsam_merge (
    input  logic               i_clk,
    input  logic [2:0]         i_en,
    input  mlsam_pkg::t_prod   i_left  [mlsam_pkg::FIELD_LINES],
    input  mlsam_pkg::t_prod   i_right [mlsam_pkg::FIELD_LINES],
    input  mlsam_pkg::t_master i_master,
    output mlsam_pkg::t_mix    o_left,
    output mlsam_pkg::t_mix    o_right
);
    import mlsam_pkg::*;

    t_pair r_left_pair  [2];
    t_pair r_right_pair [2];
    t_sum  r_left_sum;
    t_sum  r_right_sum;
    t_mix  r_left_mix;
    t_mix  r_right_mix;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_left_pair[0]  <= PAIR_W'(i_left[0])  + PAIR_W'(i_left[1]);
            r_left_pair[1]  <= PAIR_W'(i_left[2])  + PAIR_W'(i_left[3]);
            r_right_pair[0] <= PAIR_W'(i_right[0]) + PAIR_W'(i_right[1]);
            r_right_pair[1] <= PAIR_W'(i_right[2]) + PAIR_W'(i_right[3]);
        end
        if (i_en[1]) begin
            r_left_sum  <= SUM_W'(r_left_pair[0])  + SUM_W'(r_left_pair[1]);
            r_right_sum <= SUM_W'(r_right_pair[0]) + SUM_W'(r_right_pair[1]);
        end
        if (i_en[2]) begin
            r_left_mix  <= MIX_W'(r_left_sum)  * MIX_W'(signed'({1'b0, i_master}));
            r_right_mix <= MIX_W'(r_right_sum) * MIX_W'(signed'({1'b0, i_master}));
        end
    end

    assign o_left  = r_left_mix;
    assign o_right = r_right_mix;

endmodule

[sv/mlsam_scale.sv]
`timescale 1ns / 1ps

module mlsam_scale #(
    parameter int LEVEL_MAX = mlsam_pkg::LEVEL_MAX_DEF
) (
    input  logic                                  i_clk,
    input  logic [mlsam_pkg::SCALE_STAGES-1:0]    i_en,
    input  mlsam_pkg::t_mix                       i_mix,
    output mlsam_pkg::t_sample                    o_sample
);
    import mlsam_pkg::*;

    localparam int     QW   = $clog2(LEVEL_MAX + 1);
    localparam int     MW   = MIX_W;
    localparam longint DIV  = longint'(LEVEL_MAX) * longint'(LEVEL_MAX);
    localparam longint SAT  = (longint'(LEVEL_MAX) + 1) * DIV;
    // Below SAT the magnitude fits in XW bits and the quotient is at most LEVEL_MAX.
    localparam int     XW   = $clog2(SAT);
    localparam int     DW   = $clog2(DIV + 1);
    localparam int     SH   = (DW > 16) ? DW - 16 : 0;
    localparam int     HW   = XW - SH;
    localparam int     RS   = HW + 1;
    localparam longint RCP  = (longint'(1) << (RS + SH)) / DIV;
    localparam int     RW   = $clog2(RCP + 1);
    localparam int     PW   = HW + RW;
    localparam logic [MW-1:0] SAT_LIM = MW'(SAT);
    localparam logic [XW-1:0] DIV_X   = XW'(DIV);
    localparam logic [RW-1:0] RCP_W   = RW'(RCP);

    // Stage 0 takes the magnitude. Stage 1 checks for overflow and estimates the
    // quotient from the upper magnitude bits; the estimate is low by at most one.
    // Stage 2 multiplies it back and stage 3 corrects it by the remainder.
    logic          r_s0_neg;
    logic [MW-1:0] r_s0_mag;
    logic          r_s1_neg;
    logic          r_s1_sat;
    logic [XW-1:0] r_s1_x;
    logic [QW-1:0] r_s1_qe;
    logic          r_s2_neg;
    logic          r_s2_sat;
    logic [XW-1:0] r_s2_x;
    logic [QW-1:0] r_s2_qe;
    logic [XW-1:0] r_s2_prod;
    logic          r_s3_neg;
    logic          r_s3_sat;
    logic [QW-1:0] r_s3_q;

    logic [HW-1:0] w_xhi;
    logic [PW-1:0] w_est;
    logic [XW-1:0] w_rem;

    assign w_xhi = r_s0_mag[XW-1:SH];
    assign w_est = PW'(w_xhi) * PW'(RCP_W);
    assign w_rem = r_s2_x - r_s2_prod;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s0_neg <= i_mix[MW-1];
            r_s0_mag <= i_mix[MW-1] ? MW'(-i_mix) : MW'(i_mix);
        end
        if (i_en[1]) begin
            r_s1_neg <= r_s0_neg;
            r_s1_sat <= r_s0_mag >= SAT_LIM;
            r_s1_x   <= r_s0_mag[XW-1:0];
            r_s1_qe  <= w_est[RS +: QW];
        end
        if (i_en[2]) begin
            r_s2_neg  <= r_s1_neg;
            r_s2_sat  <= r_s1_sat;
            r_s2_x    <= r_s1_x;
            r_s2_qe   <= r_s1_qe;
            r_s2_prod <= XW'(r_s1_qe) * DIV_X;
        end
        if (i_en[3]) begin
            r_s3_neg <= r_s2_neg;
            r_s3_sat <= r_s2_sat;
            r_s3_q   <= r_s2_qe + QW'(w_rem >= DIV_X);
        end
    end

    logic [SAMPLE_W-1:0] w_mag;

    assign w_mag    = r_s3_sat ? SAMPLE_W'(LEVEL_MAX) : SAMPLE_W'(r_s3_q);
    assign o_sample = r_s3_neg ? t_sample'(-w_mag) : t_sample'(w_mag);

endmodule

[sv/multi_line_stereo_audio_mixer_core.sv]
`timescale 1ns / 1ps

// Four-line stereo mixer. Each item carries a left and right sample per line and a mask of
// active lines; every active line is scaled by its level, the sides are summed, scaled by
// the master level (zero while muted), divided by LEVEL_MAX squared toward zero and
// saturated to +/-LEVEL_MAX. One item is taken per clock while input is ready. An item
// passes through one stage for the line products, two for the adder tree, one for the
// master multiply and four for the divide and clip, which uses a reciprocal estimate and
// one correction step, and then through the output register. Stalls on the output only
// fill empty stages, so bubbles are squeezed out before input stops.
// Configuration writes take effect at once and are meant to happen only while idle.
module multi_line_stereo_audio_mixer_core #(
    parameter int LINES     = mlsam_pkg::LINES_DEF,
    parameter int LEVEL_MAX = mlsam_pkg::LEVEL_MAX_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // line0_left, line0_right, line1_left, line1_right, ... line3_right
    input  logic [mlsam_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,
    // active_mask
    input  logic [mlsam_pkg::FIELD_LINES-1:0]      i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // left_out, right_out
    output logic [mlsam_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    // any_active
    output logic [0:0]                             o_m_axis_tuser,
    input  logic                                   i_cfg_we,
    input  logic [mlsam_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [mlsam_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import mlsam_pkg::*;

    localparam int NSTG = 4 + SCALE_STAGES;
    localparam int NL   = (LINES < FIELD_LINES) ? LINES : FIELD_LINES;
    localparam logic [FIELD_LINES-1:0] LINE_MASK = FIELD_LINES'((1 << NL) - 1);
    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = SAMPLE_W'(LEVEL_MAX);

    // Configuration registers.
    t_level  r_line_level [FIELD_LINES];
    t_master r_master_gain;
    logic    r_master_mute;
    t_master w_master;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FIELD_LINES; i++) begin
                r_line_level[i] <= '0;
            end
            r_master_gain <= MASTER_W'(LEVEL_MAX / 2);
            r_master_mute <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx) inside
                CFG_LINE0_LEVEL, CFG_LINE1_LEVEL, CFG_LINE2_LEVEL, CFG_LINE3_LEVEL: begin
                    r_line_level[i_cfg_idx[1:0]] <= i_cfg_data[LEVEL_W-1:0];
                end
                CFG_MASTER_GAIN: begin
                    r_master_gain <= i_cfg_data[MASTER_W-1:0];
                end
                CFG_MASTER_MUTE: begin
                    r_master_mute <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_master = r_master_mute ? '0 : r_master_gain;

    // Stage valids and load enables. A stage may load when it or any stage after it
    // is empty, or when the output register is free.
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] r_any;
    logic [NSTG-1:0] w_en;
    logic            w_out_en;
    logic            r_out_vld;
    t_sample         r_out_left;
    t_sample         r_out_right;
    logic            r_out_any;

    assign w_out_en = !r_out_vld || i_m_axis_tready;

    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            w_en[k] = w_out_en || ((~r_vld & ~((NSTG)'((1 << k) - 1))) != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (w_out_en) begin
                r_out_vld <= r_vld[NSTG-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_any[0] <= (i_s_axis_tuser & LINE_MASK) != '0;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_en[k]) begin
                r_any[k] <= r_any[k-1];
            end
        end
    end

    // Per-line lanes.
    t_prod w_left_prod  [FIELD_LINES];
    t_prod w_right_prod [FIELD_LINES];

    for (genvar i = 0; i < FIELD_LINES; i++) begin : g_lane
        mlsam_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en[0]),
            .i_active (i_s_axis_tuser[i] & LINE_MASK[i]),
            .i_left   (t_sample'(i_s_axis_tdata[2*i*SAMPLE_W +: SAMPLE_W])),
            .i_right  (t_sample'(i_s_axis_tdata[(2*i+1)*SAMPLE_W +: SAMPLE_W])),
            .i_level  (r_line_level[i]),
            .o_left   (w_left_prod[i]),
            .o_right  (w_right_prod[i])
        );
    end

    t_mix w_left_mix;
    t_mix w_right_mix;

    mlsam_merge u_merge (
        .i_clk    (i_clk),
        .i_en     (w_en[3:1]),
        .i_left   (w_left_prod),
        .i_right  (w_right_prod),
        .i_master (w_master),
        .o_left   (w_left_mix),
        .o_right  (w_right_mix)
    );

    t_sample w_left_out;
    t_sample w_right_out;

    mlsam_scale #(
        .LEVEL_MAX (LEVEL_MAX)
    ) u_scale_left (
        .i_clk    (i_clk),
        .i_en     (w_en[NSTG-1:4]),
        .i_mix    (w_left_mix),
        .o_sample (w_left_out)
    );

    mlsam_scale #(
        .LEVEL_MAX (LEVEL_MAX)
    ) u_scale_right (
        .i_clk    (i_clk),
        .i_en     (w_en[NSTG-1:4]),
        .i_mix    (w_right_mix),
        .o_sample (w_right_out)
    );

    always_ff @(posedge i_clk) begin
        if (w_out_en && r_vld[NSTG-1]) begin
            r_out_left  <= w_left_out;
            r_out_right <= w_right_out;
            r_out_any   <= r_any[NSTG-1];
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out_right, r_out_left};
    assign o_m_axis_tuser  = r_out_any;

    // With no line active both sums are zero, so the result must be silence.
    a_silent_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata == '0)
        else $error("silent frame produced a nonzero sample");

    a_left_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> $signed(o_m_axis_tdata[SAMPLE_W-1:0]) >= -OUT_MAX &&
                            $signed(o_m_axis_tdata[SAMPLE_W-1:0]) <= OUT_MAX)
        else $error("left sample outside the saturation range");

    a_right_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> $signed(o_m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]) >= -OUT_MAX &&
                            $signed(o_m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]) <= OUT_MAX)
        else $error("right sample outside the saturation range");

    // A finished item in the last stage must not vanish while the output is blocked.
    a_last_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-1] && !w_out_en |=> r_vld[NSTG-1] && o_m_axis_tvalid)
        else $error("item dropped from the last pipeline stage");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    import mlsam_pkg::*;

    localparam int MIX_LATENCY    = 5 + SCALE_STAGES;
    localparam int SETTLE_CYCLES  = MIX_LATENCY + 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_CAP     = 100;

    // Indexes that map to no register; writes there must leave every setting alone.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    typedef logic [IN_DATA_W-1:0] t_frame;

    typedef struct {
        t_sample left;
        t_sample right;
        logic    any_active;
    } t_mix_result;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    t_frame                 s_tdata;
    logic [FIELD_LINES-1:0] s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Mixer settings as the block should hold them.
    t_level  line_level [FIELD_LINES];
    t_master master_vol;
    logic    muted;

    t_mix_result pending_mixes[$];
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    int          tx_idle_pct    = 12;
    int          rx_idle_pct    = 75;

    multi_line_stereo_audio_mixer_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    always @(negedge clk) begin
        m_tready = ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic t_sample scale_and_clip(longint acc, longint gain);
        longint q;
        q = (acc * gain) / (longint'(LEVEL_MAX_DEF) * longint'(LEVEL_MAX_DEF));
        if (q > LEVEL_MAX_DEF) q = LEVEL_MAX_DEF;
        if (q < -LEVEL_MAX_DEF) q = -LEVEL_MAX_DEF;
        return t_sample'(q);
    endfunction

    function automatic t_mix_result mix_frame(t_frame samples, logic [FIELD_LINES-1:0] mask);
        t_mix_result r;
        longint      acc_l;
        longint      acc_r;
        longint      gain;
        acc_l = 0;
        acc_r = 0;
        r.any_active = 1'b0;
        for (int ln = 0; ln < FIELD_LINES && ln < LINES_DEF; ln++) begin
            if (mask[ln]) begin
                acc_l += longint'(t_sample'(samples[32*ln +: 16])) * longint'(line_level[ln]);
                acc_r += longint'(t_sample'(samples[32*ln+16 +: 16])) * longint'(line_level[ln]);
                r.any_active = 1'b1;
            end
        end
        gain = muted ? 0 : longint'(master_vol);
        r.left  = scale_and_clip(acc_l, gain);
        r.right = scale_and_clip(acc_r, gain);
        return r;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        mismatch_count++;
        // Keep the log readable when the block is badly broken.
        if (mismatch_count <= REPORT_CAP)
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    endtask

    always @(posedge clk) begin
        t_mix_result want;
        t_sample     got_left;
        t_sample     got_right;
        if (rst_n && m_tvalid && m_tready) begin
            got_left  = t_sample'(m_tdata[15:0]);
            got_right = t_sample'(m_tdata[31:16]);
            if (pending_mixes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_CAP)
                    $display("%0t: unexpected item, expected none, got left %0d right %0d any %0d",
                             $time, got_left, got_right, m_tuser[0]);
            end else begin
                want = pending_mixes.pop_front();
                if (got_left !== want.left) report_mismatch("left_out", want.left, got_left);
                if (got_right !== want.right) report_mismatch("right_out", want.right, got_right);
                if (m_tuser[0] !== want.any_active)
                    report_mismatch("any_active", want.any_active, m_tuser[0]);
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        case (idx) inside
            CFG_LINE0_LEVEL, CFG_LINE1_LEVEL, CFG_LINE2_LEVEL, CFG_LINE3_LEVEL:
                line_level[idx[1:0]] = data;
            CFG_MASTER_GAIN: master_vol = data[MASTER_W-1:0];
            CFG_MASTER_MUTE: muted = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_frame(t_frame samples, logic [FIELD_LINES-1:0] mask);
        @(negedge clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = samples;
        s_tuser  = mask;
        do @(posedge clk); while (!s_tready);
        pending_mixes.push_back(mix_frame(samples, mask));
    endtask

    // Hold the sender off until every result is out and the pipeline is empty.
    task automatic drain_mixer;
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_mixes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic t_frame uniform_frame(t_sample left, t_sample right);
        t_frame f;
        for (int ln = 0; ln < FIELD_LINES; ln++) begin
            f[32*ln +: 16]    = left;
            f[32*ln+16 +: 16] = right;
        end
        return f;
    endfunction

    function automatic t_sample random_sample;
        case ($urandom_range(0, 7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return t_sample'($urandom_range(0, 30)) - 16'sd15;
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_frame random_frame;
        t_frame  f;
        t_sample left;
        for (int ln = 0; ln < FIELD_LINES; ln++) begin
            left = random_sample();
            f[32*ln +: 16] = left;
            // A mono source repeats its left sample on the right.
            f[32*ln+16 +: 16] = ($urandom_range(0, 3) == 0) ? left : random_sample();
        end
        return f;
    endfunction

    task automatic randomize_mix_settings;
        t_level  lvl;
        t_master gain;
        for (int ln = 0; ln < FIELD_LINES; ln++) begin
            case ($urandom_range(0, 5))
                0: lvl = '0;
                1: lvl = '1;
                default: lvl = t_level'($urandom_range(0, 65535) >> $urandom_range(0, 15));
            endcase
            write_reg(CFG_LINE0_LEVEL + CFG_IDX_W'(ln), lvl);
        end
        case ($urandom_range(0, 5))
            0: gain = '0;
            1: gain = '1;
            default: gain = t_master'($urandom_range(0, 32767) >> $urandom_range(0, 14));
        endcase
        write_reg(CFG_MASTER_GAIN, {1'($urandom_range(0, 1)), gain});
        write_reg(CFG_MASTER_MUTE, {15'($urandom), 1'($urandom_range(0, 5) == 0)});
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_HI : CFG_UNMAPPED_LO, 16'($urandom));
    endtask

    // Levels are zero out of reset, so everything mixes to silence.
    task automatic test_reset_defaults;
        send_frame(uniform_frame(16'sd32767, -16'sd32768), 4'hF);
        send_frame(uniform_frame(-16'sd32768, 16'sd32767), 4'h0);
        drain_mixer();
    endtask

    task automatic test_full_scale;
        for (int ln = 0; ln < FIELD_LINES; ln++)
            write_reg(CFG_LINE0_LEVEL + CFG_IDX_W'(ln), 16'hFFFF);
        // The top bit of the gain and the upper bits of the mute are not stored.
        write_reg(CFG_MASTER_GAIN, 16'hFFFF);
        write_reg(CFG_MASTER_MUTE, 16'hFFFE);
        send_frame(uniform_frame(16'sd32767, 16'sd32767), 4'hF);
        send_frame(uniform_frame(-16'sd32768, -16'sd32768), 4'hF);
        send_frame(uniform_frame(16'sd32767, -16'sd32768), 4'hF);
        for (int ln = 0; ln < FIELD_LINES; ln++)
            send_frame(uniform_frame(-16'sd32768, 16'sd32767), 4'(1 << ln));
        send_frame(uniform_frame(-16'sd32768, 16'sd32767), 4'h0);
        send_frame(uniform_frame(16'sd1234, 16'sd1234), 4'h5);
        drain_mixer();
    endtask

    task automatic test_truncation;
        t_frame f;
        write_reg(CFG_LINE0_LEVEL, 16'd32767);
        write_reg(CFG_LINE1_LEVEL, 16'd32767);
        write_reg(CFG_LINE2_LEVEL, 16'd0);
        write_reg(CFG_LINE3_LEVEL, 16'd0);
        write_reg(CFG_MASTER_GAIN, 16'd32767);
        // Unity overall gain passes samples straight through.
        send_frame(uniform_frame(-16'sd5, 16'sd5), 4'h1);
        drain_mixer();
        write_reg(CFG_MASTER_GAIN, 16'd16383);
        // Just under half gain: -2.5 and 2.5 both truncate toward zero.
        send_frame(uniform_frame(-16'sd5, 16'sd5), 4'h1);
        send_frame(uniform_frame(16'sd32767, -16'sd32768), 4'h1);
        f = uniform_frame(16'sd1000, -16'sd700);
        f[32 +: 16] = -16'sd1000;
        f[48 +: 16] = 16'sd700;
        send_frame(f, 4'h3);
        drain_mixer();
    endtask

    task automatic test_mute_and_unmapped;
        write_reg(CFG_MASTER_MUTE, 16'h0001);
        send_frame(uniform_frame(16'sd32767, -16'sd32768), 4'hF);
        drain_mixer();
        // Unmuting restores the gain that was kept meanwhile.
        write_reg(CFG_MASTER_MUTE, 16'h0002);
        send_frame(uniform_frame(-16'sd5, 16'sd5), 4'h1);
        drain_mixer();
        write_reg(CFG_UNMAPPED_LO, 16'h0000);
        write_reg(CFG_UNMAPPED_HI, 16'hFFFF);
        send_frame(uniform_frame(-16'sd5, 16'sd5), 4'h1);
        drain_mixer();
        write_reg(CFG_MASTER_GAIN, 16'h8000);
        send_frame(uniform_frame(16'sd32767, 16'sd32767), 4'hF);
        drain_mixer();
    endtask

    task automatic test_random_traffic(int n_items, int tx_pct, int rx_pct);
        int sent;
        int seg_len;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_items) begin
            randomize_mix_settings();
            seg_len = $urandom_range(40, 160);
            for (int k = 0; k < seg_len && sent < n_items; k++) begin
                send_frame(random_frame(), 4'($urandom_range(0, 15)));
                sent++;
            end
            drain_mixer();
        end
    endtask

    initial begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        for (int ln = 0; ln < FIELD_LINES; ln++) line_level[ln] = '0;
        master_vol = t_master'(LEVEL_MAX_DEF / 2);
        muted      = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_full_scale();
        test_truncation();
        test_mute_and_unmapped();
        test_random_traffic(583, 12, 75);
        test_random_traffic(583, 75, 12);
        test_random_traffic(584, 0, 0);
        drain_mixer();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/mlsam_pkg.sv
sv/mlsam_lane.sv
sv/mlsam_merge.sv
sv/mlsam_scale.sv
sv/multi_line_stereo_audio_mixer_core.sv
tb/sv/tb_top.sv
